FILE: rtl/adif_pkg.sv
package adif_pkg;

  // Field widths
  localparam int unsigned CountW = 6;
  localparam int unsigned LenW   = 10;
  localparam int unsigned AccW   = LenW + 1;
  localparam int unsigned ProdW  = AccW + 3;

  // Defaults for the field limits
  localparam int unsigned DefMaxNameChars = 49;
  localparam int unsigned DefMaxTypeChars = 49;

  // Register map
  localparam int unsigned PAddrW = 3;
  localparam logic [LenW-1:0] MaxValueLenReset = LenW'(1000);
  localparam logic [0:0] RegIdxMaxValueLength = 1'b0;

  // Character codes
  localparam logic [7:0] ChEnd   = 8'h00;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [4:0] {
    PH_SKIP  = 5'b00001,
    PH_NAME  = 5'b00010,
    PH_COUNT = 5'b00100,
    PH_TYPE  = 5'b01000,
    PH_VALUE = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NAME  = 3'd0,
    KIND_TYPE  = 3'd1,
    KIND_VALUE = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERR   = 3'd4,
    KIND_EOT   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ERR_EMPTY_NAME = 3'd0,
    ERR_LONG_NAME  = 3'd1,
    ERR_BAD_DIGIT  = 3'd2,
    ERR_OVER_LIMIT = 3'd3,
    ERR_LONG_TYPE  = 3'd4,
    ERR_END_IN_TAG = 3'd5
  } cause_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_char;
    logic       last_of_item;
    cause_e     error_cause;
  } res_t;

endpackage

FILE: rtl/adif_if.sv
interface adif_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface adif_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_char;
  logic       last_of_item;
  logic [2:0] error_cause;

  modport source (output valid, output kind, output out_char, output last_of_item,
                  output error_cause, input ready);
  modport sink (input valid, input kind, input out_char, input last_of_item,
                input error_cause, output ready);
endinterface

FILE: rtl/adif_parse.sv
module adif_parse import adif_pkg::*; #(
  parameter int unsigned MaxNameChars = DefMaxNameChars,
  parameter int unsigned MaxTypeChars = DefMaxTypeChars
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      text_byte_i,
  input  logic [LenW-1:0] max_len_i,
  output logic            res_valid_o,
  output res_t            res_o
);

  phase_e             phase_q, phase_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [LenW-1:0]    rem_q, rem_d;

  logic               is_end, is_lt, is_colon, is_gt, is_digit;
  logic [AccW-1:0]    acc_limit;
  logic [ProdW-1:0]   acc_x10;
  logic [LenW-1:0]    rem_dec;

  // Classify the byte
  assign is_end   = (text_byte_i == ChEnd);
  assign is_lt    = (text_byte_i == ChLt);
  assign is_colon = (text_byte_i == ChColon);
  assign is_gt    = (text_byte_i == ChGt);
  assign is_digit = (text_byte_i >= ChZero) && (text_byte_i <= ChNine);

  // Decimal accumulate with saturation at limit plus one
  assign acc_limit = AccW'(max_len_i) + AccW'(1);
  assign acc_x10   = ProdW'({acc_q, 3'b000}) + ProdW'({acc_q, 1'b0})
                   + ProdW'(text_byte_i[3:0]);
  assign rem_dec   = rem_q - LenW'(1);

  // Step the parser
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_NAME, out_char: 8'h00, last_of_item: 1'b0,
                    error_cause: ERR_EMPTY_NAME};
    unique case (phase_q)
      PH_SKIP: begin
        if (is_end) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_EOT;
        end else if (is_lt) begin
          phase_d = PH_NAME;
          cnt_d   = '0;
        end
      end
      PH_NAME: begin
        if (is_end) begin
          phase_d           = PH_SKIP;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_ERR;
          res_o.error_cause = ERR_END_IN_TAG;
        end else if (is_colon || is_gt) begin
          if (cnt_q == '0) begin
            phase_d           = PH_SKIP;
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_ERR;
            res_o.error_cause = ERR_EMPTY_NAME;
          end else if (is_gt) begin
            // tag without a count closes the item at once
            phase_d            = PH_SKIP;
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_END;
            res_o.last_of_item = 1'b1;
          end else begin
            acc_d   = '0;
            phase_d = PH_COUNT;
          end
        end else if (cnt_q >= CountW'(MaxNameChars)) begin
          phase_d           = PH_SKIP;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_ERR;
          res_o.error_cause = ERR_LONG_NAME;
        end else begin
          cnt_d          = cnt_q + CountW'(1);
          res_valid_o    = 1'b1;
          res_o.kind     = KIND_NAME;
          res_o.out_char = text_byte_i;
        end
      end
      PH_COUNT: begin
        if (is_end) begin
          phase_d           = PH_SKIP;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_ERR;
          res_o.error_cause = ERR_END_IN_TAG;
        end else if (is_colon || is_gt) begin
          if (acc_q > AccW'(max_len_i)) begin
            phase_d           = PH_SKIP;
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_ERR;
            res_o.error_cause = ERR_OVER_LIMIT;
          end else if (is_gt) begin
            if (acc_q == '0) begin
              phase_d            = PH_SKIP;
              res_valid_o        = 1'b1;
              res_o.kind         = KIND_END;
              res_o.last_of_item = 1'b1;
            end else begin
              rem_d   = acc_q[LenW-1:0];
              phase_d = PH_VALUE;
            end
          end else begin
            cnt_d   = '0;
            phase_d = PH_TYPE;
          end
        end else if (!is_digit) begin
          phase_d           = PH_SKIP;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_ERR;
          res_o.error_cause = ERR_BAD_DIGIT;
        end else if (acc_x10 > ProdW'(acc_limit)) begin
          acc_d = acc_limit;
        end else begin
          acc_d = acc_x10[AccW-1:0];
        end
      end
      PH_TYPE: begin
        if (is_end) begin
          phase_d           = PH_SKIP;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_ERR;
          res_o.error_cause = ERR_END_IN_TAG;
        end else if (is_gt) begin
          if (acc_q == '0) begin
            phase_d            = PH_SKIP;
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_END;
            res_o.last_of_item = 1'b1;
          end else begin
            rem_d   = acc_q[LenW-1:0];
            phase_d = PH_VALUE;
          end
        end else if (cnt_q >= CountW'(MaxTypeChars)) begin
          phase_d           = PH_SKIP;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_ERR;
          res_o.error_cause = ERR_LONG_TYPE;
        end else begin
          cnt_d          = cnt_q + CountW'(1);
          res_valid_o    = 1'b1;
          res_o.kind     = KIND_TYPE;
          res_o.out_char = text_byte_i;
        end
      end
      PH_VALUE: begin
        if (is_end) begin
          // text ran out inside the value: end the item early
          phase_d            = PH_SKIP;
          rem_d              = '0;
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_END;
          res_o.last_of_item = 1'b1;
        end else begin
          rem_d              = rem_dec;
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_VALUE;
          res_o.out_char     = text_byte_i;
          res_o.last_of_item = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_d = PH_SKIP;
          end
        end
      end
      default: begin
        phase_d = PH_SKIP;
      end
    endcase
  end

  // Advance state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      cnt_q   <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
    end
  end

endmodule

FILE: rtl/adif_tag_stream_parser_top.sv
// Channel   Direction  Payload                                        Accepted when
// text_i    in         text_byte[7:0]                                 valid && ready
// res_o     out        kind[2:0] out_char[7:0] last_of_item           valid && ready
//                      error_cause[2:0]
// apb       in/out     max_value_length at byte address 0             psel && penable && pwrite
//
// One byte is taken per cycle while the skid entry is empty; its result, if any, is registered.
// The parse state sits in one register bank updated by a single step of logic.
// A result register plus one skid entry keep text_i open while res_o stalls;
// text_i drops ready only when both hold a request.
// Reset clears the parse state and both buffer entries; max_value_length returns to 1000.
module adif_tag_stream_parser_top import adif_pkg::*; #(
  parameter int unsigned MaxNameChars = DefMaxNameChars,
  parameter int unsigned MaxTypeChars = DefMaxTypeChars
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  adif_text_if.sink         text_i,
  adif_res_if.source        res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [LenW-1:0] max_len_q;
  logic            cfg_wr;
  logic            cfg_hit;

  logic            step;
  logic            res_valid;
  res_t            res;

  logic            out_valid_q, out_valid_d;
  res_t            out_q, out_d;
  logic            skid_valid_q, skid_valid_d;
  res_t            skid_q, skid_d;
  logic            drain;

  // Configuration register
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = (paddr[PAddrW-1:2] == RegIdxMaxValueLength);
  assign prdata  = cfg_hit ? 32'(max_len_q) : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxValueLenReset;
    end else if (cfg_wr && cfg_hit) begin
      max_len_q <= pwdata[LenW-1:0];
    end
  end

  // Parser core
  assign text_i.ready = !skid_valid_q;
  assign step         = text_i.valid && !skid_valid_q;

  adif_parse #(
    .MaxNameChars (MaxNameChars),
    .MaxTypeChars (MaxTypeChars)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .text_byte_i (text_i.text_byte),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register with skid entry
  assign drain = out_valid_q && res_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (drain || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = step && res_valid;
        out_d       = res;
      end
    end else if (step && res_valid) begin
      // hold the new request while the output is stalled
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = out_q.kind;
  assign res_o.out_char     = out_q.out_char;
  assign res_o.last_of_item = out_q.last_of_item;
  assign res_o.error_cause  = out_q.error_cause;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a request while the result register is empty");

  a_cause_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind != KIND_ERR) |-> (out_q.error_cause == ERR_EMPTY_NAME))
    else $error("error cause set on a non-error result");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last_of_item) |->
      (out_q.kind == KIND_VALUE || out_q.kind == KIND_END))
    else $error("last_of_item set on a result that cannot end an item");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && cfg_hit) |=> (max_len_q == $past(pwdata[LenW-1:0])))
    else $error("max_value_length write not taken");
`endif

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adif_pkg::*;

  localparam int unsigned ResetCycles    = 5;
  localparam int unsigned DrainCycles    = 4;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned CycleLimit     = 2000000;
  localparam int unsigned NameLimit      = DefMaxNameChars;
  localparam int unsigned TypeLimit      = DefMaxTypeChars;
  localparam int unsigned ValueCutLen    = 24;

  localparam logic [PAddrW-1:0] MaxLenAddr    = PAddrW'(4 * RegIdxMaxValueLength);
  localparam logic [PAddrW-1:0] UnusedRegAddr = PAddrW'(4);

  // The cause field reads as zero on every result that is not an error
  localparam cause_e NoCause = ERR_EMPTY_NAME;

  // Track parser state and hold the results still owed by the block
  class tag_scoreboard;
    phase_e          phase;
    logic [5:0]      field_chars;
    int unsigned     length_acc;
    logic [LenW-1:0] value_left;
    logic [LenW-1:0] max_len;
    res_t            pending_results[$];
    int              errors;
    int              kind_seen[6];

    function new();
      phase       = PH_SKIP;
      field_chars = '0;
      length_acc  = 0;
      value_left  = '0;
      max_len     = MaxValueLenReset;
      errors      = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void set_limit(logic [LenW-1:0] value);
      max_len = value;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void queue_result(kind_e k, logic [7:0] ch, logic last, cause_e cause);
      res_t r;
      r.kind          = k;
      r.out_char      = ch;
      r.last_of_item  = last;
      r.error_cause   = cause;
      pending_results = {pending_results, r};
    endfunction

    function void abort_tag(cause_e cause);
      phase = PH_SKIP;
      queue_result(KIND_ERR, 8'h00, 1'b0, cause);
    endfunction

    // Start the value, or close the item at once on a zero count
    function void open_value();
      if (length_acc == 0) begin
        phase = PH_SKIP;
        queue_result(KIND_END, 8'h00, 1'b1, NoCause);
      end else begin
        value_left = length_acc[LenW-1:0];
        phase      = PH_VALUE;
      end
    endfunction

    // Advance the parse by one accepted text byte
    function void note_text_byte(logic [7:0] b);
      case (phase)
        PH_SKIP: begin
          if (b == ChEnd) begin
            queue_result(KIND_EOT, 8'h00, 1'b0, NoCause);
          end else if (b == ChLt) begin
            phase       = PH_NAME;
            field_chars = '0;
          end
        end
        PH_NAME: begin
          if (b == ChEnd) begin
            abort_tag(ERR_END_IN_TAG);
          end else if (b == ChColon || b == ChGt) begin
            if (field_chars == 0) begin
              abort_tag(ERR_EMPTY_NAME);
            end else if (b == ChGt) begin
              phase = PH_SKIP;
              queue_result(KIND_END, 8'h00, 1'b1, NoCause);
            end else begin
              length_acc = 0;
              phase      = PH_COUNT;
            end
          end else if (field_chars >= NameLimit) begin
            abort_tag(ERR_LONG_NAME);
          end else begin
            field_chars = field_chars + 6'd1;
            queue_result(KIND_NAME, b, 1'b0, NoCause);
          end
        end
        PH_COUNT: begin
          if (b == ChEnd) begin
            abort_tag(ERR_END_IN_TAG);
          end else if (b == ChColon || b == ChGt) begin
            if (length_acc > max_len) begin
              abort_tag(ERR_OVER_LIMIT);
            end else if (b == ChGt) begin
              open_value();
            end else begin
              field_chars = '0;
              phase       = PH_TYPE;
            end
          end else if (b < ChZero || b > ChNine) begin
            abort_tag(ERR_BAD_DIGIT);
          end else begin
            // Saturate one above the limit so the over-limit check still fires
            length_acc = length_acc * 10 + (b - ChZero);
            if (length_acc > max_len + 1) length_acc = max_len + 1;
          end
        end
        PH_TYPE: begin
          if (b == ChEnd) begin
            abort_tag(ERR_END_IN_TAG);
          end else if (b == ChGt) begin
            open_value();
          end else if (field_chars >= TypeLimit) begin
            abort_tag(ERR_LONG_TYPE);
          end else begin
            field_chars = field_chars + 6'd1;
            queue_result(KIND_TYPE, b, 1'b0, NoCause);
          end
        end
        PH_VALUE: begin
          if (b == ChEnd) begin
            // End of text cuts the value short
            phase      = PH_SKIP;
            value_left = '0;
            queue_result(KIND_END, 8'h00, 1'b1, NoCause);
          end else begin
            value_left = value_left - 1'b1;
            if (value_left == 0) begin
              phase = PH_SKIP;
              queue_result(KIND_VALUE, b, 1'b1, NoCause);
            end else begin
              queue_result(KIND_VALUE, b, 1'b0, NoCause);
            end
          end
        end
        default: phase = PH_SKIP;
      endcase
    endfunction

    // Compare one delivered result with the oldest one owed
    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d char %02h", got.kind, got.out_char);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      kind_seen[want.kind]++;
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.out_char !== want.out_char) begin
        $error("out_char: expected %02h, got %02h", want.out_char, got.out_char);
        errors++;
      end
      if (got.last_of_item !== want.last_of_item) begin
        $error("last_of_item: expected %0b, got %0b", want.last_of_item, got.last_of_item);
        errors++;
      end
      if (got.error_cause !== want.error_cause) begin
        $error("error_cause: expected %0d, got %0d", want.error_cause, got.error_cause);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PAddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  adif_text_if text_if ();
  adif_res_if  res_if ();

  tag_scoreboard sb = new();

  logic [7:0]  text_q[$];
  bit          steady_flow   = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned cycle_count   = 0;
  int unsigned bytes_fed     = 0;
  int unsigned mid_limit;

  adif_tag_stream_parser_top #(
    .MaxNameChars(NameLimit),
    .MaxTypeChars(TypeLimit)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Note accepted bytes first, then check delivered results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (text_if.valid && text_if.ready) begin
        sb.note_text_byte(text_if.text_byte);
        bytes_fed <= bytes_fed + 1;
      end
      if (res_if.valid && res_if.ready) begin
        sb.check_result('{kind: kind_e'(res_if.kind), out_char: res_if.out_char,
                          last_of_item: res_if.last_of_item,
                          error_cause: cause_e'(res_if.error_cause)});
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Stall the result side at random, with one long hold-off on request
  initial begin
    int unsigned hold;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      hold = long_hold_req ? LongHoldCycles : pick_gap();
      long_hold_req = 1'b0;
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic write_reg(input logic [PAddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (addr == MaxLenAddr) sb.set_limit(data[LenW-1:0]);
  endtask

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    do @(posedge clk_i); while (!text_if.ready);
  endtask

  task automatic send_text();
    while (text_q.size() != 0) send_byte(text_q.pop_front());
  endtask

  // Wait until every owed result is in and the parser has settled
  task automatic drain();
    text_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic void add_text(input logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) add_text(s[i]);
  endfunction

  function automatic void push_run(input logic [7:0] ch, input int unsigned n);
    repeat (n) add_text(ch);
  endfunction

  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == ChColon || b == ChGt);
    return b;
  endfunction

  function automatic logic [7:0] type_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == ChGt);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == ChLt);
    return b;
  endfunction

  // Full byte range, leaning on the delimiters and digits
  function automatic logic [7:0] wild_byte();
    if ($urandom_range(0, 2) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       return ChEnd;
      1:       return ChColon;
      2:       return ChGt;
      3:       return ChLt;
      4:       return ChZero;
      default: return ChNine;
    endcase
  endfunction

  // Append one tag: mostly well formed with random content, the rest broken
  function automatic void add_random_tag(input int unsigned lim);
    int unsigned r;
    int unsigned name_len;
    int unsigned type_len;
    int unsigned cnt;
    int unsigned sent;
    string       digits;
    repeat ($urandom_range(0, 3)) add_text(noise_byte());
    if ($urandom_range(0, 39) == 0) add_text(ChEnd);
    add_text(ChLt);
    if ($urandom_range(0, 99) < 25) begin
      repeat ($urandom_range(1, 6)) add_text(wild_byte());
      return;
    end
    name_len = ($urandom_range(0, 19) == 0) ? $urandom_range(NameLimit - 1, NameLimit + 1)
                                            : $urandom_range(1, 8);
    repeat (name_len) add_text(name_byte());
    r = $urandom_range(0, 99);
    if (r < 8) begin
      add_text(ChGt);
      return;
    end
    if (r < 11) begin
      add_text(ChEnd);
      return;
    end
    add_text(ChColon);
    case ($urandom_range(0, 9))
      0:       cnt = lim;
      1:       cnt = lim + 1;
      2:       cnt = $urandom_range(0, lim);
      3:       cnt = $urandom_range(lim + 2, lim + 60000);
      4:       cnt = 0;
      default: cnt = (lim == 0) ? 0 : $urandom_range(1, (lim < 12) ? lim : 12);
    endcase
    digits = $sformatf("%0d", cnt);
    if ($urandom_range(0, 4) == 0) digits = {"0", digits};
    if ($urandom_range(0, 49) == 0) begin
      digits = "";
      cnt    = 0;
    end
    push_str(digits);
    if ($urandom_range(0, 29) == 0) begin
      add_text(ChEnd);
      return;
    end
    if ($urandom_range(0, 1) == 1) begin
      add_text(ChColon);
      type_len = ($urandom_range(0, 19) == 0) ? $urandom_range(TypeLimit - 1, TypeLimit + 1)
                                              : $urandom_range(0, 3);
      repeat (type_len) add_text(type_byte());
      if ($urandom_range(0, 29) == 0) begin
        add_text(ChEnd);
        return;
      end
    end
    add_text(ChGt);
    if (cnt > lim) return;
    // Cut long values short with end of text to keep the run small
    sent = (cnt > ValueCutLen) ? $urandom_range(0, ValueCutLen) : cnt;
    if (sent == cnt && cnt > 0 && $urandom_range(0, 19) == 0) sent = $urandom_range(0, cnt - 1);
    repeat (sent) add_text(8'($urandom_range(1, 255)));
    if (sent < cnt) add_text(ChEnd);
  endfunction

  task automatic run_random(input int unsigned nbytes);
    while (text_q.size() < nbytes) add_random_tag(sb.max_len);
    send_text();
    drain();
  endtask

  initial begin
    rst_ni            = 1'b0;
    text_if.valid     = 1'b0;
    text_if.text_byte = 8'h00;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases at the widest limit; the unmapped write must change nothing
    write_reg(MaxLenAddr, 32'd1000);
    write_reg(UnusedRegAddr, 32'd5);
    push_str("junk");
    add_text(ChEnd);
    push_str("<A><:x<>");
    push_str("<AB:3>xyz<AB:0><AB:><AB:0:S>");
    push_str("<CALL:4:S>ABCD<A:2:a:b>xy");
    push_str("<A:1x<A:1<B>");
    push_str("<A:1001><A:99999999999><A:1000>ab");
    add_text(ChEnd);
    push_str("<A<B:2>");
    add_text(8'hFF);
    add_text(8'h80);
    add_text(ChLt);
    push_run("N", NameLimit);
    push_str(":1>v<");
    push_run("N", NameLimit + 1);
    push_str("<T:1:");
    push_run("t", TypeLimit);
    push_str(">v<T:1:");
    push_run("t", TypeLimit + 1);
    push_str("<AB");
    add_text(ChEnd);
    push_str("<A:12");
    add_text(ChEnd);
    push_str("<A:1:T");
    add_text(ChEnd);
    push_str("<A:2>q");
    add_text(ChEnd);
    send_text();
    drain();

    // Zero limit: only empty values pass
    write_reg(MaxLenAddr, 32'd0);
    push_str("<A:0><A:1><A:><A>x");
    run_random(300);

    write_reg(MaxLenAddr, 32'd1);
    run_random(300);

    // Hold results back for a long stretch so the input backs up
    write_reg(MaxLenAddr, 32'd7);
    long_hold_req = 1'b1;
    run_random(350);

    mid_limit = $urandom_range(2, 998);
    write_reg(MaxLenAddr, mid_limit);
    run_random(350);

    // Back to the widest limit, part of it with no idling on the input
    write_reg(MaxLenAddr, 32'd1000);
    steady_flow = 1'b1;
    run_random(150);
    steady_flow = 1'b0;
    run_random(200);

    $display("Fed %0d text bytes under max_value_length 1000, 0, 1, 7, %0d, 1000.",
             bytes_fed, mid_limit);
    $display("Checked %0d name, %0d type, %0d value, %0d item-end, %0d error, %0d text-end.",
             sb.kind_seen[KIND_NAME], sb.kind_seen[KIND_TYPE], sb.kind_seen[KIND_VALUE],
             sb.kind_seen[KIND_END], sb.kind_seen[KIND_ERR], sb.kind_seen[KIND_EOT]);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
